### sv/first_fit_pool_allocator_core_macros.svh
// ---------------------------------------------------------------------------
// First-fit pool allocator: assertion macros
// Shared property shorthands for the allocator's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_POOL_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_POOL_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FFPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FFPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/ffpa_pkg.sv
// ---------------------------------------------------------------------------
// First-fit pool allocator package
// Shared widths, defaults, operation codes and the block table entry type.
// ---------------------------------------------------------------------------
package ffpa_pkg;

   // Defaults for the top-level parameters.
   localparam int POOL_BYTES_DEF   = 65536;
   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int HEADER_BYTES_DEF = 24;
   localparam int WORD_BYTES_DEF   = 8;

   // Byte offsets and sizes never exceed the 64 KiB pool limit.
   localparam int VAL_W         = 17;
   localparam int MANAGER_BYTES = 16;
   localparam int POOL_LIMIT    = 65536;
   localparam int POOL_MIN      = 64;
   localparam logic [VAL_W-1:0] POOL_RESET = 17'd4096;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_LARGEST = 2'd2,
      OP_REINIT  = 2'd3
   } op_type;

   // One block table entry: header offset, data size, free mark.
   typedef struct packed {
      logic [VAL_W-1:0] start;
      logic [VAL_W-1:0] bytes;
      logic             free;
   } entry_type;

endpackage

### sv/ffpa_req_if.sv
// ---------------------------------------------------------------------------
// First-fit pool allocator request channel
// Valid/ready channel carrying one operation beat.
// ---------------------------------------------------------------------------
interface ffpa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] request_size;
   logic [15:0] free_offset;

   modport source (output valid, output operation, output request_size,
                   output free_offset, input ready);
   modport sink   (input valid, input operation, input request_size,
                   input free_offset, output ready);
endinterface

### sv/ffpa_rsp_if.sv
// ---------------------------------------------------------------------------
// First-fit pool allocator response channel
// Valid/ready channel carrying one result beat.
// ---------------------------------------------------------------------------
interface ffpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] alloc_offset;
   logic        ok;
   logic [15:0] largest_free;

   modport source (output valid, output alloc_offset, output ok,
                   output largest_free, input ready);
   modport sink   (input valid, input alloc_offset, input ok,
                   input largest_free, output ready);
endinterface

### sv/ffpa_ram.sv
// ---------------------------------------------------------------------------
// First-fit pool allocator RAM
// Generic one-write, one-read memory with registered read data.
// ---------------------------------------------------------------------------
module ffpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ffpa_round.sv
// ---------------------------------------------------------------------------
// First-fit pool allocator request rounding
// Rounds a request up to a word multiple by reciprocal multiplication.
// ---------------------------------------------------------------------------
module ffpa_round import ffpa_pkg::*; #(
   parameter int WORD_BYTES = WORD_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [15:0]      value,
   output logic             done,
   output logic [VAL_W-1:0] rounded
);

   // The reciprocal of the word size is exact for every 17-bit dividend.
   localparam int SH    = VAL_W + $clog2(WORD_BYTES);
   localparam int RECIP = ((1 << SH) + WORD_BYTES - 1) / WORD_BYTES;
   localparam int PW    = VAL_W + SH;

   logic             done_ff, done_in;
   logic [15:0]      val_ff, val_in;
   logic [VAL_W-1:0] sum;
   logic [PW-1:0]    prod;
   logic [VAL_W-1:0] quot;

   // Capture the request; the rounded value is ready in the following cycle.
   always_comb begin
      done_in = start;
      val_in  = start ? value : val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      val_ff <= val_in;
   end

   // Divide the value plus the word size less one, then scale back up.
   assign sum     = {1'b0, val_ff} + VAL_W'(WORD_BYTES - 1);
   assign prod    = PW'(sum) * PW'(RECIP);
   assign quot    = VAL_W'(prod >> SH);
   assign rounded = VAL_W'(quot * VAL_W'(WORD_BYTES));
   assign done    = done_ff;

endmodule

### sv/first_fit_pool_allocator_core.sv
// ---------------------------------------------------------------------------
// First-fit pool allocator core
// Address-ordered block table in RAM, walked by a small sequencer that
// merges free runs, finds the first fit, splits blocks and frees them.
// ---------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  req_ch   in   operation, request_size, free_offset
//  rsp_ch   out  alloc_offset, ok, largest_free
//  csr_*    in   pool_size write (csr_we, csr_wdata)
//
// The table RAM has a single registered read port, so every table walk reads
// one entry at a time. After reset the block writes the initial entry before
// it takes a request. One result may wait in the output register; a second one
// holds the sequencer, and so the next request, until it leaves.
// ---------------------------------------------------------------------------
module first_fit_pool_allocator_core import ffpa_pkg::*; #(
   parameter int POOL_BYTES   = POOL_BYTES_DEF,
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int WORD_BYTES   = WORD_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   ffpa_req_if.sink         req_ch,
   ffpa_rsp_if.source       rsp_ch,
   input  logic             csr_we,
   input  logic [VAL_W-1:0] csr_wdata
);

   `include "first_fit_pool_allocator_core_macros.svh"

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int POOL_HI = (POOL_BYTES < POOL_LIMIT) ? POOL_BYTES : POOL_LIMIT;
   localparam logic [VAL_W-1:0] HI_V  = VAL_W'(POOL_HI);
   localparam logic [VAL_W-1:0] MIN_V = VAL_W'(POOL_MIN);
   localparam logic [VAL_W-1:0] HB_V  = VAL_W'(HEADER_BYTES);
   localparam logic [VAL_W-1:0] OVH_V = VAL_W'(MANAGER_BYTES + HEADER_BYTES);
   localparam logic [VAL_W-1:0] FLOOR_V = VAL_W'(HEADER_BYTES + WORD_BYTES);
   localparam logic [VAL_W-1:0] MGR_V = VAL_W'(MANAGER_BYTES);
   localparam logic [CW-1:0]    MAX_C = CW'(MAX_BLOCKS);
   localparam int EW = $bits(entry_type);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_ROUND, S_MRD, S_MWT, S_MEND,
      S_SHR, S_SHW, S_SPL1, S_SPL2, S_FRD, S_FWT, S_DONE
   } state_type;

   state_type        state_ff;
   logic [VAL_W-1:0] pool_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    idx_ff;
   logic [IW-1:0]    wp_ff;
   entry_type        pend_ff;
   logic             fit_found_ff;
   logic [IW-1:0]    fit_idx_ff;
   logic [VAL_W-1:0] fit_start_ff;
   logic [VAL_W-1:0] fit_bytes_ff;
   logic [VAL_W-1:0] best_ff;
   logic [VAL_W-1:0] r_ff;
   op_type           op_ff;
   logic [15:0]      off_ff;
   logic             init_rsp_ff;
   logic [15:0]      res_off_ff;
   logic             res_ok_ff;
   logic [15:0]      res_lg_ff;
   logic             rsp_valid_ff;
   logic [15:0]      rsp_off_ff;
   logic             rsp_ok_ff;
   logic [15:0]      rsp_lg_ff;

   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   entry_type        wr_data;
   logic [IW-1:0]    rd_addr;
   logic [EW-1:0]    rd_raw;
   entry_type        rd_e;
   entry_type        init_e;
   logic [VAL_W-1:0] pool_c;
   logic             round_start;
   logic             round_done;
   logic [VAL_W-1:0] round_val;
   logic             fin_fit;
   logic             join_now;
   logic             accept;
   logic [CW-1:0]    count_new;

   assign rd_e   = entry_type'(rd_raw);
   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   // Initial single free block from the clamped pool size.
   always_comb begin
      pool_c = pool_ff;
      if (pool_c < MIN_V) pool_c = MIN_V;
      if (pool_c > HI_V)  pool_c = HI_V;
      init_e.start = MGR_V;
      init_e.bytes = (pool_c > OVH_V) ? pool_c - OVH_V : '0;
      init_e.free  = 1'b1;
   end

   // Checks on the merged entry being retired to the table.
   assign fin_fit  = pend_ff.free && !fit_found_ff &&
                     ({1'b0, pend_ff.bytes} >= ({1'b0, r_ff} + {1'b0, HB_V}));
   assign join_now = pend_ff.free && rd_e.free;
   assign count_new = CW'(wp_ff) + CW'(1);

   // Table RAM port control.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wp_ff;
      wr_data = pend_ff;
      rd_addr = idx_ff[IW-1:0];
      case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = init_e;
         end
         S_MWT: begin
            wr_en = (idx_ff != '0) && !join_now;
         end
         S_MEND: begin
            wr_en = 1'b1;
         end
         S_SHW: begin
            wr_en   = 1'b1;
            wr_addr = IW'(idx_ff + CW'(1));
            wr_data = rd_e;
         end
         S_SPL1: begin
            wr_en   = 1'b1;
            wr_addr = fit_idx_ff;
            wr_data = '{start: fit_start_ff, bytes: r_ff, free: 1'b0};
         end
         S_SPL2: begin
            wr_en   = 1'b1;
            wr_addr = fit_idx_ff + IW'(1);
            wr_data = '{start: fit_start_ff + HB_V + r_ff,
                        bytes: fit_bytes_ff - r_ff - HB_V, free: 1'b1};
         end
         S_FWT: begin
            wr_en   = ((rd_e.start + HB_V) == {1'b0, off_ff});
            wr_addr = idx_ff[IW-1:0];
            wr_data = '{start: rd_e.start, bytes: rd_e.bytes, free: 1'b1};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign round_start = accept && (op_type'(req_ch.operation) == OP_ALLOC);

   ffpa_round #(.WORD_BYTES(WORD_BYTES)) u_round (
      .clock   (clock),
      .reset   (reset),
      .start   (round_start),
      .value   (req_ch.request_size),
      .done    (round_done),
      .rounded (round_val)
   );

   ffpa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (EW'(wr_data)),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // Sequencer and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pool_ff      <= POOL_RESET;
         count_ff     <= CW'(1);
         init_rsp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            pool_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: begin
               count_ff <= CW'(1);
               state_ff <= init_rsp_ff ? S_DONE : S_IDLE;
            end
            S_IDLE: begin
               if (accept) begin
                  op_ff        <= op_type'(req_ch.operation);
                  off_ff       <= req_ch.free_offset;
                  res_off_ff   <= '0;
                  res_ok_ff    <= 1'b1;
                  res_lg_ff    <= '0;
                  idx_ff       <= '0;
                  wp_ff        <= '0;
                  fit_found_ff <= 1'b0;
                  best_ff      <= FLOOR_V;
                  r_ff         <= '0;
                  init_rsp_ff  <= 1'b1;
                  case (op_type'(req_ch.operation))
                     OP_ALLOC:   state_ff <= S_ROUND;
                     OP_FREE:    state_ff <= S_FRD;
                     OP_LARGEST: state_ff <= S_MRD;
                     OP_REINIT:  state_ff <= S_INIT;
                     default:    state_ff <= S_INIT;
                  endcase
               end
            end
            S_ROUND: begin
               if (round_done) begin
                  r_ff     <= round_val;
                  state_ff <= S_MRD;
               end
            end
            S_MRD: begin
               state_ff <= S_MWT;
            end
            S_MWT: begin
               // Fold the entry into the pending run or retire the run.
               if (idx_ff == '0) begin
                  pend_ff <= rd_e;
               end else if (join_now) begin
                  pend_ff.bytes <= pend_ff.bytes + rd_e.bytes + HB_V;
               end else begin
                  if (fin_fit) begin
                     fit_found_ff <= 1'b1;
                     fit_idx_ff   <= wp_ff;
                     fit_start_ff <= pend_ff.start;
                     fit_bytes_ff <= pend_ff.bytes;
                  end
                  if (pend_ff.free && (pend_ff.bytes > best_ff)) begin
                     best_ff <= pend_ff.bytes;
                  end
                  wp_ff   <= wp_ff + IW'(1);
                  pend_ff <= rd_e;
               end
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= ((idx_ff + CW'(1)) == count_ff) ? S_MEND : S_MRD;
            end
            S_MEND: begin
               count_ff <= count_new;
               if (op_ff == OP_LARGEST) begin
                  if (pend_ff.free && (pend_ff.bytes > best_ff)) begin
                     res_lg_ff <= 16'(pend_ff.bytes - FLOOR_V);
                  end else begin
                     res_lg_ff <= 16'(best_ff - FLOOR_V);
                  end
                  state_ff <= S_DONE;
               end else if ((!fit_found_ff && !fin_fit) || (count_new >= MAX_C)) begin
                  res_ok_ff <= 1'b0;
                  state_ff  <= S_DONE;
               end else begin
                  if (!fit_found_ff) begin
                     fit_found_ff <= 1'b1;
                     fit_idx_ff   <= wp_ff;
                     fit_start_ff <= pend_ff.start;
                     fit_bytes_ff <= pend_ff.bytes;
                     state_ff     <= S_SPL1;
                  end else if ((CW'(fit_idx_ff) + CW'(1)) < count_new) begin
                     idx_ff   <= count_new - CW'(1);
                     state_ff <= S_SHR;
                  end else begin
                     state_ff <= S_SPL1;
                  end
               end
            end
            S_SHR: begin
               state_ff <= S_SHW;
            end
            S_SHW: begin
               // Move entries up one place to open the split slot.
               if (idx_ff == (CW'(fit_idx_ff) + CW'(1))) begin
                  state_ff <= S_SPL1;
               end else begin
                  idx_ff   <= idx_ff - CW'(1);
                  state_ff <= S_SHR;
               end
            end
            S_SPL1: begin
               res_off_ff <= 16'(fit_start_ff + HB_V);
               state_ff   <= S_SPL2;
            end
            S_SPL2: begin
               count_ff <= count_ff + CW'(1);
               state_ff <= S_DONE;
            end
            S_FRD: begin
               state_ff <= S_FWT;
            end
            S_FWT: begin
               if ((rd_e.start + HB_V) == {1'b0, off_ff}) begin
                  state_ff <= S_DONE;
               end else if ((idx_ff + CW'(1)) == count_ff) begin
                  res_ok_ff <= 1'b0;
                  state_ff  <= S_DONE;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_FRD;
               end
            end
            S_DONE: begin
               // Hand the result to the output register once it is free.
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_off_ff   <= res_off_ff;
                  rsp_ok_ff    <= res_ok_ff;
                  rsp_lg_ff    <= res_lg_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.alloc_offset = rsp_off_ff;
   assign rsp_ch.ok           = rsp_ok_ff;
   assign rsp_ch.largest_free = rsp_lg_ff;

   // Concurrent checks on the sequencer and result register.
   `FFPA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= MAX_C,
      "block count beyond table depth")
   `FFPA_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ch.ready,
      "request taken while a request is still in work")
   `FFPA_ASSERT_NOW(a_fail_no_offset, clock, reset, rsp_valid_ff && !rsp_ok_ff,
      rsp_off_ff == '0, "failed result carries a nonzero offset")
   `FFPA_ASSERT_NOW(a_offset_xor_largest, clock, reset,
      rsp_valid_ff && (rsp_lg_ff != '0), rsp_off_ff == '0,
      "result carries both an offset and a largest size")

endmodule
